FILE: hw/rtl/kmd_pkg.sv
// Shared constants and types for the key matrix debouncer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package kmd_pkg;

  localparam int ROW_W      = 3;   // scan_row / event_row
  localparam int COL_IN_W   = 8;   // column_levels_n and the output masks
  localparam int TIME_W     = 32;  // now_ms
  localparam int DEB_W      = 16;  // debounce_ms
  localparam int MAX_ROWS   = 1 << ROW_W;
  localparam int IN_TDATA_W = 48;  // 43 payload bits padded to bytes
  localparam int OUT_TDATA_W = 32; // 27 payload bits padded to bytes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEFAULT_ROW_COUNT    = 8;
  localparam int DEFAULT_COLUMN_COUNT = 8;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_MS = 2'd0,
    CFG_PRESS_EN    = 2'd1,
    CFG_RELEASE_EN  = 2'd2
  } cfg_reg_t;

endpackage

FILE: hw/rtl/key_matrix_debounce.sv
// Key matrix debouncer top level: handshakes, config registers, result register.
// Depends on kmd_pkg, kmd_state and kmd_row_eval.
//
// Usage:
//   in_*  : one sampled row per transfer (scan_row, column_levels_n, now_ms).
//   out_* : exactly one result per input transfer (event_row, press_mask,
//           release_mask, stable_row_state), in input order.
//   cfg_* : register writes (0 debounce_ms, 1 press enable, 2 release enable);
//           cfg_ready is always high, writes to other indexes are dropped.
// A row goes from the input register through the result register to out_tdata.
// Throughput: one row per cycle while the output is not stalled. The input
// register feeds a single row evaluation and state update per cycle, so rows of
// the same index may follow back to back.
// Stall: while out_tready is low a full result register holds; in_tready stays
// high until the input register is also full, then drops until out moves.
// Reset: all rows released, change times zero, debounce 10 ms, both report
// enables set; both stages empty. Rows at or above ROW_COUNT change no state
// and report zero masks and state.
`timescale 1ns / 1ps
module key_matrix_debounce #(
  parameter int ROW_COUNT    = kmd_pkg::DEFAULT_ROW_COUNT,
  parameter int COLUMN_COUNT = kmd_pkg::DEFAULT_COLUMN_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: scan_row[2:0], column_levels_n[10:3], now_ms[42:11], zero pad
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [kmd_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: event_row[2:0], press_mask[10:3], release_mask[18:11],
  //            stable_row_state[26:19], zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kmd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ROWS   = (ROW_COUNT < kmd_pkg::MAX_ROWS) ? ROW_COUNT : kmd_pkg::MAX_ROWS;
  localparam int COLS   = (COLUMN_COUNT < kmd_pkg::COL_IN_W) ? COLUMN_COUNT
                                                             : kmd_pkg::COL_IN_W;
  localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RW     = kmd_pkg::ROW_W;
  localparam int CW     = kmd_pkg::COL_IN_W;
  localparam int TW     = kmd_pkg::TIME_W;

  // configuration
  logic [kmd_pkg::DEB_W-1:0] debounce_r;
  logic                      press_en_r;
  logic                      release_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= kmd_pkg::DEBOUNCE_RESET;
      press_en_r   <= 1'b1;
      release_en_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (kmd_pkg::cfg_reg_t'(cfg_index))
        kmd_pkg::CFG_DEBOUNCE_MS: debounce_r   <= cfg_data;
        kmd_pkg::CFG_PRESS_EN:    press_en_r   <= cfg_data[0];
        kmd_pkg::CFG_RELEASE_EN:  release_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  logic          in_vld_r;
  logic [RW-1:0] in_row_r;
  logic [CW-1:0] in_lvl_r;
  logic [TW-1:0] in_now_r;
  logic          advance;

  assign advance   = in_vld_r && (!out_tvalid || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_row_r <= in_tdata[RW-1:0];
      in_lvl_r <= in_tdata[RW +: CW];
      in_now_r <= in_tdata[RW+CW +: TW];
    end
  end

  // row evaluation
  logic              in_range;
  logic [RIDX_W-1:0] row_idx;
  logic [COLS-1:0]   old_stable;
  logic [COLS-1:0]   old_raw;
  logic [COLS*TW-1:0] old_time;
  logic [COLS-1:0]   new_stable;
  logic [COLS-1:0]   new_raw;
  logic [COLS*TW-1:0] new_time;
  logic [COLS-1:0]   press;
  logic [COLS-1:0]   release_bits;

  assign in_range = {1'b0, in_row_r} < (RW+1)'(ROWS);
  assign row_idx  = in_range ? in_row_r[RIDX_W-1:0] : '0;

  kmd_state #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_row    (row_idx),
    .rd_stable (old_stable),
    .rd_raw    (old_raw),
    .rd_time   (old_time),
    .wr_en     (advance && in_range),
    .wr_row    (row_idx),
    .wr_stable (new_stable),
    .wr_raw    (new_raw),
    .wr_time   (new_time)
  );

  kmd_row_eval #(
    .COLS (COLS)
  ) u_eval (
    .levels_n     (in_lvl_r),
    .now          (in_now_r),
    .debounce     (debounce_r),
    .press_en     (press_en_r),
    .release_en   (release_en_r),
    .old_stable   (old_stable),
    .old_raw      (old_raw),
    .old_time     (old_time),
    .new_stable   (new_stable),
    .new_raw      (new_raw),
    .new_time     (new_time),
    .press        (press),
    .release_bits (release_bits)
  );

  // result register
  logic          out_vld_r;
  logic [RW-1:0] out_row_r;
  logic [CW-1:0] out_press_r;
  logic [CW-1:0] out_release_r;
  logic [CW-1:0] out_stable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_row_r     <= in_row_r;
      out_press_r   <= in_range ? CW'(press) : '0;
      out_release_r <= in_range ? CW'(release_bits) : '0;
      out_stable_r  <= in_range ? CW'(new_stable) : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(kmd_pkg::OUT_TDATA_W - RW - 3*CW)'(0),
                       out_stable_r, out_release_r, out_press_r, out_row_r};

endmodule

FILE: hw/rtl/kmd_state.sv
// Per-row key state store: debounced state, last raw sample and change times.
// Depends on kmd_pkg. Read is combinational, write at the clock edge.
`timescale 1ns / 1ps
module kmd_state #(
  parameter int ROWS = kmd_pkg::DEFAULT_ROW_COUNT,
  parameter int COLS = kmd_pkg::DEFAULT_COLUMN_COUNT,
  localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [RIDX_W-1:0]               rd_row,
  output logic [COLS-1:0]                 rd_stable,
  output logic [COLS-1:0]                 rd_raw,
  output logic [COLS*kmd_pkg::TIME_W-1:0] rd_time,
  input  logic                            wr_en,
  input  logic [RIDX_W-1:0]               wr_row,
  input  logic [COLS-1:0]                 wr_stable,
  input  logic [COLS-1:0]                 wr_raw,
  input  logic [COLS*kmd_pkg::TIME_W-1:0] wr_time
);

  logic [COLS-1:0]                 stable_r [ROWS];
  logic [COLS-1:0]                 raw_r    [ROWS];
  logic [COLS*kmd_pkg::TIME_W-1:0] time_r   [ROWS];
  logic [ROWS-1:0]                 time_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        stable_r[r] <= '0;
        raw_r[r]    <= '0;
      end
      time_vld_r <= '0;
    end else if (wr_en) begin
      stable_r[wr_row]   <= wr_stable;
      raw_r[wr_row]      <= wr_raw;
      time_vld_r[wr_row] <= 1'b1;
    end
  end

  // change times carry no reset; a row never written reads as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_r[wr_row] <= wr_time;
    end
  end

  assign rd_stable = stable_r[rd_row];
  assign rd_raw    = raw_r[rd_row];
  assign rd_time   = time_vld_r[rd_row] ? time_r[rd_row] : '0;

endmodule

FILE: hw/rtl/kmd_row_eval.sv
// Debounce evaluation of one sampled row, all columns side by side.
// Depends on kmd_pkg. Purely combinational.
`timescale 1ns / 1ps
module kmd_row_eval #(
  parameter int COLS = kmd_pkg::DEFAULT_COLUMN_COUNT
) (
  input  logic [kmd_pkg::COL_IN_W-1:0]    levels_n,
  input  logic [kmd_pkg::TIME_W-1:0]      now,
  input  logic [kmd_pkg::DEB_W-1:0]       debounce,
  input  logic                            press_en,
  input  logic                            release_en,
  input  logic [COLS-1:0]                 old_stable,
  input  logic [COLS-1:0]                 old_raw,
  input  logic [COLS*kmd_pkg::TIME_W-1:0] old_time,
  output logic [COLS-1:0]                 new_stable,
  output logic [COLS-1:0]                 new_raw,
  output logic [COLS*kmd_pkg::TIME_W-1:0] new_time,
  output logic [COLS-1:0]                 press,
  output logic [COLS-1:0]                 release_bits
);

  localparam int TW = kmd_pkg::TIME_W;

  for (genvar c = 0; c < COLS; c++) begin : g_col
    logic          cur;
    logic          changed;
    logic [TW-1:0] t_last;
    logic [TW-1:0] elapsed;
    logic          settle;

    assign cur     = ~levels_n[c];
    assign changed = cur != old_raw[c];
    // restart the timer on a raw change, elapsed is then zero
    assign t_last  = changed ? now : old_time[c*TW +: TW];
    assign elapsed = now - t_last;
    assign settle  = (elapsed > TW'(debounce)) && (cur != old_stable[c]);

    assign new_time[c*TW +: TW] = t_last;
    assign new_raw[c]           = cur;
    assign new_stable[c]        = settle ? cur : old_stable[c];
    assign press[c]             = settle && cur && press_en;
    assign release_bits[c]      = settle && !cur && release_en;
  end

endmodule
